[sv/fdr_pkg.sv]
package fdr_pkg;

    localparam int unsigned FRAC_BITS = 15;
    localparam logic [15:0] FX_ONE    = 16'h8000;
    localparam logic [31:0] FX_ONE_SQ = 32'h4000_0000;

    // register byte addresses on the configuration port
    localparam logic [2:0] ADDR_ETA_OUTSIDE = 3'h0;
    localparam logic [2:0] ADDR_ETA_INSIDE  = 3'h4;

    // payload carried down the pipeline, each stage updates the fields it works on
    typedef struct packed {
        logic [15:0] eta_i;
        logic [15:0] eta_t;
        logic [15:0] c;
        logic        tir;
        logic [31:0] rem;
        logic [31:0] res;
        logic [15:0] sin_t;
        logic [32:0] num_a;
        logic [32:0] den_a;
        logic [32:0] num_b;
        logic [32:0] den_b;
        logic        sat_a;
        logic        sat_b;
        logic [15:0] q_a;
        logic [15:0] q_b;
        logic [15:0] sq_a;
        logic [15:0] sq_b;
    } pipe_t;

endpackage

[sv/fresnel_dielectric_reflectance_top.sv]
// throughput: one transaction per cycle while the output is not stalled, set by the 71-stage pipeline with one
//   square root, long division or fraction divide step per stage
// a stall on the output freezes the whole pipeline; nothing is lost or repeated
// reset (rst_n, async, active low) clears all valid bits and sets both indices to 4096
module fresnel_dielectric_reflectance_top
    import fdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] cos_incident (signed q1.15)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] reflectance (unsigned q1.15)
    output logic        m_tuser,   // [0] total_reflection
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // stage map
    localparam int S_IN   = 0;   // decode direction, swap indices
    localparam int S_SQI  = 1;   // 1 - cos^2
    localparam int S_ISQ1 = 2;   // 16 root steps -> sin_i
    localparam int S_MUL  = 18;  // eta_i * sin_i
    localparam int S_TIR  = 19;  // total internal reflection test
    localparam int S_DIV  = 20;  // 15 division steps -> sin_t
    localparam int S_SQT  = 35;  // 1 - sin_t^2
    localparam int S_ISQ2 = 36;  // 16 root steps -> cos_t
    localparam int S_PROD = 52;  // four index * cosine products
    localparam int S_DS   = 53;  // difference and sum per polarization
    localparam int S_FDIV = 54;  // 15 fraction divide steps, both lanes
    localparam int S_SQR  = 69;  // square the amplitude ratios
    localparam int S_OUT  = 70;  // mean, saturation, output register
    localparam int NST    = 71;

    logic [15:0] eta_outside_reg;
    logic [15:0] eta_inside_reg;
    logic        cfg_wr;

    pipe_t st_reg  [NST];
    pipe_t st_next [NST];
    logic  vld_reg [NST];
    logic  adv;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_outside_reg <= 16'd4096;
            eta_inside_reg  <= 16'd4096;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ADDR_ETA_INSIDE[2])
                eta_inside_reg  <= pwdata[15:0];
            else
                eta_outside_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == ADDR_ETA_INSIDE[2])
            prdata = {16'd0, eta_inside_reg};
        else
            prdata = {16'd0, eta_outside_reg};
    end

    // ---------------- handshake ----------------
    // the whole pipeline moves when the output register is free or being drained
    assign adv      = !vld_reg[S_OUT] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[S_OUT];
    assign m_tdata  = st_reg[S_OUT].sq_a;
    assign m_tuser  = st_reg[S_OUT].tir;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NST; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // ---------------- input decode ----------------
    always_comb
    begin : c_in
        logic        neg;
        logic [15:0] mag;
        neg = s_tdata[15];
        mag = 16'd0 - s_tdata;
        st_next[S_IN] = '0;
        // a leaving ray (cosine zero or negative) swaps the indices
        if (neg || (s_tdata == 16'd0))
        begin
            st_next[S_IN].eta_i = eta_inside_reg;
            st_next[S_IN].eta_t = eta_outside_reg;
            st_next[S_IN].c     = neg ? mag : 16'd0;
        end
        else
        begin
            st_next[S_IN].eta_i = eta_outside_reg;
            st_next[S_IN].eta_t = eta_inside_reg;
            st_next[S_IN].c     = s_tdata;
        end
        if (st_next[S_IN].c > FX_ONE)
            st_next[S_IN].c = FX_ONE;
    end

    // 1 - cos^2
    always_comb
    begin
        st_next[S_SQI]     = st_reg[S_SQI-1];
        st_next[S_SQI].rem = FX_ONE_SQ - (32'(st_reg[S_SQI-1].c) * 32'(st_reg[S_SQI-1].c));
        st_next[S_SQI].res = 32'd0;
    end

    // ---------------- square roots, one result bit per stage ----------------
    for (genvar r = 0; r < 2; r++)
    begin : g_root
        for (genvar j = 0; j < 16; j++)
        begin : g_step
            localparam int S = (r == 0 ? S_ISQ1 : S_ISQ2) + j;
            localparam logic [31:0] BIT = 32'd1 << (2 * (15 - j));
            always_comb
            begin : c_step
                logic [32:0] trial;
                trial      = {1'b0, st_reg[S-1].res} + {1'b0, BIT};
                st_next[S] = st_reg[S-1];
                if ({1'b0, st_reg[S-1].rem} >= trial)
                begin
                    st_next[S].rem = st_reg[S-1].rem - trial[31:0];
                    st_next[S].res = (st_reg[S-1].res >> 1) + BIT;
                end
                else
                begin
                    st_next[S].res = st_reg[S-1].res >> 1;
                end
            end
        end
    end

    // eta_i * sin_i, zero transmitted index forces total reflection
    always_comb
    begin
        st_next[S_MUL]     = st_reg[S_MUL-1];
        st_next[S_MUL].rem = 32'(st_reg[S_MUL-1].eta_i) * 32'(st_reg[S_MUL-1].res[15:0]);
        st_next[S_MUL].tir = (st_reg[S_MUL-1].eta_t == 16'd0);
    end

    // sin_t >= 1 exactly when eta_i * sin_i >= eta_t * one
    always_comb
    begin
        st_next[S_TIR]       = st_reg[S_TIR-1];
        st_next[S_TIR].sin_t = 16'd0;
        if (st_reg[S_TIR-1].rem >= {1'b0, st_reg[S_TIR-1].eta_t, 15'd0})
            st_next[S_TIR].tir = 1'b1;
    end

    // ---------------- long division by eta_t, msb first ----------------
    for (genvar j = 0; j < 15; j++)
    begin : g_div
        localparam int S = S_DIV + j;
        localparam int K = 14 - j;
        always_comb
        begin : c_div
            logic [31:0] dsh;
            dsh        = 32'(st_reg[S-1].eta_t) << K;
            st_next[S] = st_reg[S-1];
            if (st_reg[S-1].rem >= dsh)
            begin
                st_next[S].rem      = st_reg[S-1].rem - dsh;
                st_next[S].sin_t[K] = 1'b1;
            end
        end
    end

    // 1 - sin_t^2
    always_comb
    begin
        st_next[S_SQT]     = st_reg[S_SQT-1];
        st_next[S_SQT].rem = FX_ONE_SQ
            - (32'(st_reg[S_SQT-1].sin_t) * 32'(st_reg[S_SQT-1].sin_t));
        st_next[S_SQT].res = 32'd0;
    end

    // products: parallel uses (eta_t*c, eta_i*cos_t), perpendicular (eta_i*c, eta_t*cos_t)
    always_comb
    begin : c_prod
        logic [15:0] cos_t;
        cos_t                = st_reg[S_PROD-1].res[15:0];
        st_next[S_PROD]       = st_reg[S_PROD-1];
        st_next[S_PROD].num_a = 33'(32'(st_reg[S_PROD-1].eta_t) * 32'(st_reg[S_PROD-1].c));
        st_next[S_PROD].den_a = 33'(32'(st_reg[S_PROD-1].eta_i) * 32'(cos_t));
        st_next[S_PROD].num_b = 33'(32'(st_reg[S_PROD-1].eta_i) * 32'(st_reg[S_PROD-1].c));
        st_next[S_PROD].den_b = 33'(32'(st_reg[S_PROD-1].eta_t) * 32'(cos_t));
    end

    // |x - y| over x + y; a ratio of one (or empty denominator) saturates
    always_comb
    begin : c_ds
        logic [32:0] xa, ya, xb, yb;
        xa = st_reg[S_DS-1].num_a;
        ya = st_reg[S_DS-1].den_a;
        xb = st_reg[S_DS-1].num_b;
        yb = st_reg[S_DS-1].den_b;
        st_next[S_DS]       = st_reg[S_DS-1];
        st_next[S_DS].num_a = (xa >= ya) ? xa - ya : ya - xa;
        st_next[S_DS].den_a = xa + ya;
        st_next[S_DS].num_b = (xb >= yb) ? xb - yb : yb - xb;
        st_next[S_DS].den_b = xb + yb;
        st_next[S_DS].sat_a = (st_next[S_DS].den_a == 33'd0)
                           || (st_next[S_DS].num_a >= st_next[S_DS].den_a);
        st_next[S_DS].sat_b = (st_next[S_DS].den_b == 33'd0)
                           || (st_next[S_DS].num_b >= st_next[S_DS].den_b);
        st_next[S_DS].q_a   = 16'd0;
        st_next[S_DS].q_b   = 16'd0;
    end

    // ---------------- fraction divide, both lanes ----------------
    for (genvar j = 0; j < 15; j++)
    begin : g_fdiv
        localparam int S = S_FDIV + j;
        always_comb
        begin : c_fdiv
            logic [33:0] na, nb;
            na         = {st_reg[S-1].num_a, 1'b0};
            nb         = {st_reg[S-1].num_b, 1'b0};
            st_next[S] = st_reg[S-1];
            if (na >= {1'b0, st_reg[S-1].den_a})
            begin
                st_next[S].num_a = 33'(na - {1'b0, st_reg[S-1].den_a});
                st_next[S].q_a   = {st_reg[S-1].q_a[14:0], 1'b1};
            end
            else
            begin
                st_next[S].num_a = na[32:0];
                st_next[S].q_a   = {st_reg[S-1].q_a[14:0], 1'b0};
            end
            if (nb >= {1'b0, st_reg[S-1].den_b})
            begin
                st_next[S].num_b = 33'(nb - {1'b0, st_reg[S-1].den_b});
                st_next[S].q_b   = {st_reg[S-1].q_b[14:0], 1'b1};
            end
            else
            begin
                st_next[S].num_b = nb[32:0];
                st_next[S].q_b   = {st_reg[S-1].q_b[14:0], 1'b0};
            end
        end
    end

    // square the ratios
    always_comb
    begin : c_sqr
        logic [15:0] ra, rb;
        logic [31:0] pa, pb;
        ra = st_reg[S_SQR-1].sat_a ? FX_ONE : st_reg[S_SQR-1].q_a;
        rb = st_reg[S_SQR-1].sat_b ? FX_ONE : st_reg[S_SQR-1].q_b;
        pa = 32'(ra) * 32'(ra);
        pb = 32'(rb) * 32'(rb);
        st_next[S_SQR]      = st_reg[S_SQR-1];
        st_next[S_SQR].sq_a = pa[FRAC_BITS +: 16];
        st_next[S_SQR].sq_b = pb[FRAC_BITS +: 16];
    end

    // mean of both polarizations, saturated; total reflection gives one
    always_comb
    begin : c_out
        logic [16:0] sum;
        logic [15:0] half;
        sum  = {1'b0, st_reg[S_OUT-1].sq_a} + {1'b0, st_reg[S_OUT-1].sq_b};
        half = sum[16:1];
        st_next[S_OUT] = st_reg[S_OUT-1];
        if (st_reg[S_OUT-1].tir || (half > FX_ONE))
            st_next[S_OUT].sq_a = FX_ONE;
        else
            st_next[S_OUT].sq_a = half;
    end

endmodule

[sv/fdr_chk.sv]
module fdr_chk
    import fdr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reflectance never exceeds one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata <= FX_ONE)
        else $error("reflectance above one");

    // total reflection always reports exactly one
    a_tir: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == FX_ONE)
        else $error("total reflection without full reflectance");

    // an empty output register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind fresnel_dielectric_reflectance_top fdr_chk u_fdr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/sv/tb_top.sv]
module tb_top;
    import fdr_pkg::*;

    // drain wait: the pipeline depth of the block, plus margin
    localparam int DRAIN_CYCLES = 90;
    // cycles with no transaction on any side before the run is declared hung
    localparam int HANG_LIMIT   = 4000;
    // random cosines per phase, eleven phases with fourteen directed values each
    localparam int N_RANDOM     = 145;

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } fresnel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // cosines waiting to be driven, and the predicted results still in flight
    logic [15:0] cos_pending[$];
    fresnel_t    refl_expected[$];

    // shadow copy of the two index registers
    logic [15:0] eta_out_sh;
    logic [15:0] eta_in_sh;

    int  n_fail;
    int  hang_cnt;
    bit  calm;          // stretch with no idling on either side

    fresnel_dielectric_reflectance_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // squared amplitude ratio (|x-y|/(x+y))^2 in q1.15
    function automatic logic [63:0] amp_sq(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] diff;
        logic [63:0] den;
        logic [63:0] r;
        diff = (x >= y) ? x - y : y - x;
        den  = x + y;
        if (den == 64'd0 || diff >= den)
            r = 64'd1 << FRAC_BITS;
        else
            r = (diff << FRAC_BITS) / den;
        return (r * r) >> FRAC_BITS;
    endfunction

    function automatic fresnel_t fresnel_reflect(input logic [15:0] cosv);
        fresnel_t    res;
        logic [63:0] one;
        logic [63:0] e_i;
        logic [63:0] e_t;
        logic [63:0] c;
        logic [63:0] s_i;
        logic [63:0] s_t;
        logic [63:0] c_t;
        logic [63:0] sum;
        one = 64'd1 << FRAC_BITS;
        e_i = 64'(eta_out_sh);
        e_t = 64'(eta_in_sh);
        if (cosv[15] || cosv == 16'd0)
        begin
            // leaving the medium: indices swap, cosine negated
            e_i = 64'(eta_in_sh);
            e_t = 64'(eta_out_sh);
            c   = cosv[15] ? 64'h10000 - 64'(cosv) : 64'd0;
        end
        else
            c = 64'(cosv);
        if (c > one)
            c = one;
        s_i = isqrt(one * one - c * c);
        res.tir = 1'b1;
        res.refl = (one > 64'hFFFF) ? 16'hFFFF : one[15:0];
        if (e_t == 64'd0)
            return res;
        s_t = (e_i * s_i) / e_t;
        if (s_t >= one)
            return res;
        c_t = isqrt(one * one - s_t * s_t);
        sum = (amp_sq(e_t * c, e_i * c_t) + amp_sq(e_i * c, e_t * c_t)) >> 1;
        if (sum > one)
            sum = one;
        if (sum > 64'hFFFF)
            sum = 64'hFFFF;
        res.tir  = 1'b0;
        res.refl = sum[15:0];
        return res;
    endfunction

    // driver: predicts at the accepting edge, then loads the next cosine
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                refl_expected.push_back(fresnel_reflect(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (cos_pending.size() > 0 && (calm || $urandom_range(99) >= 21))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= cos_pending.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= calm || ($urandom_range(99) >= 21);
            if (m_tvalid && m_tready)
            begin
                if (refl_expected.size() == 0)
                begin
                    $error("unexpected result transaction reflectance=%0d", m_tdata);
                    n_fail++;
                end
                else
                begin
                    fresnel_t exp_r;
                    exp_r = refl_expected.pop_front();
                    if (m_tdata !== exp_r.refl)
                    begin
                        $error("reflectance expected %0d actual %0d", exp_r.refl, m_tdata);
                        n_fail++;
                    end
                    if (m_tuser !== exp_r.tir)
                    begin
                        $error("total_reflection expected %0d actual %0d", exp_r.tir, m_tuser);
                        n_fail++;
                    end
                end
            end
        end
    end

    // watchdog: any transaction on either stream, or a config access, resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            hang_cnt <= 0;
        else
            hang_cnt <= hang_cnt + 1;
        if (hang_cnt >= HANG_LIMIT)
        begin
            $display("fresnel_dielectric_reflectance_top regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ETA_OUTSIDE)
            eta_out_sh = val;
        else
            eta_in_sh = val;
    endtask

    // wait for every queued cosine to go out and every result to come back
    task automatic drain();
        while (cos_pending.size() > 0 || s_tvalid || refl_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sweep a set of cosines: extremes first, then random, biased near the edges
    task automatic run_phase(input int n_rand);
        logic [15:0] dir_cos[$];
        dir_cos = {16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF,
                   16'h4000, 16'hC000, 16'h5A82, 16'hA57E, 16'h0100, 16'hFF00,
                   16'h5555, 16'hAAAA};
        foreach (dir_cos[i])
            cos_pending.push_back(dir_cos[i]);
        for (int i = 0; i < n_rand; i++)
        begin
            case ($urandom_range(3))
                0: cos_pending.push_back(16'($urandom_range(255)));
                1: cos_pending.push_back(16'hFFFF - 16'($urandom_range(255)));
                default: cos_pending.push_back(16'($urandom()));
            endcase
        end
    endtask

    initial
    begin
        logic [15:0] eta_sets[$];
        n_fail    = 0;
        calm      = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        eta_out_sh = 16'd4096;
        eta_in_sh  = 16'd4096;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset values first (matched indices)
        run_phase(N_RANDOM);
        drain();

        // index pairs: extremes, glass, water, inverse, random
        eta_sets = {16'd4096, 16'd6144,  16'd6144, 16'd4096,  16'd1024, 16'd65535,
                    16'd65535, 16'd1024,  16'd5448, 16'd4096,  16'd65535, 16'd65535,
                    16'd1024, 16'd1024};
        for (int p = 0; p < eta_sets.size() / 2; p++)
        begin
            reg_write(ADDR_ETA_OUTSIDE, eta_sets[2 * p]);
            reg_write(ADDR_ETA_INSIDE, eta_sets[2 * p + 1]);
            calm = (p == 3);
            run_phase(N_RANDOM);
            drain();
        end
        for (int p = 0; p < 3; p++)
        begin
            reg_write(ADDR_ETA_OUTSIDE, 16'($urandom_range(65535, 1024)));
            reg_write(ADDR_ETA_INSIDE, 16'($urandom_range(65535, 1024)));
            calm = 1'b0;
            run_phase(N_RANDOM);
            drain();
        end

        if (n_fail == 0)
            $display("fresnel_dielectric_reflectance_top regression: pass");
        else
            $display("fresnel_dielectric_reflectance_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
sv/fdr_pkg.sv
sv/fresnel_dielectric_reflectance_top.sv
sv/fdr_chk.sv
tb/sv/tb_top.sv
